### rtl/core/kf2s_pkg.sv
// ----------------------------------------------------------------------------
// kf2s_pkg
// Types, register indexes, sequencer codes and saturation helpers shared by
// the two-state Kalman filter.
// ----------------------------------------------------------------------------
package kf2s_pkg;

  typedef struct packed {
    logic signed [31:0] measured_distance;
    logic signed [31:0] measured_vibration;
  } kf2s_in_t;

  typedef struct packed {
    logic signed [31:0] filtered_distance;
    logic signed [31:0] filtered_vibration;
    logic               update_skipped;
  } kf2s_out_t;

  typedef struct packed {
    logic [30:0]        process_noise;
    logic [30:0]        dist_noise_near;
    logic [30:0]        dist_noise_far;
    logic [30:0]        vib_noise;
    logic signed [31:0] noise_switch_level;
    logic [30:0]        initial_variance;
  } kf2s_cfg_t;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_PROCESS_NOISE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DIST_NOISE_NEAR = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DIST_NOISE_FAR  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_VIB_NOISE       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SWITCH_LEVEL    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_INIT_VARIANCE   = 3'd5;

  // Dot-product slots walked by the sequencer, in order.
  typedef logic [3:0] dot_t;
  localparam dot_t DOT_DET  = 4'd0;
  localparam dot_t DOT_K0   = 4'd1;
  localparam dot_t DOT_K1   = 4'd2;
  localparam dot_t DOT_K2   = 4'd3;
  localparam dot_t DOT_K3   = 4'd4;
  localparam dot_t DOT_EST0 = 4'd5;
  localparam dot_t DOT_EST1 = 4'd6;
  localparam dot_t DOT_COV0 = 4'd7;
  localparam dot_t DOT_COV1 = 4'd8;
  localparam dot_t DOT_COV2 = 4'd9;
  localparam dot_t DOT_COV3 = 4'd10;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRED,
    ST_FORMS,
    ST_MUL,
    ST_ACC,
    ST_POST,
    ST_DIV,
    ST_FORMY,
    ST_OUT
  } kf2s_state_e;

  typedef struct packed {
    logic load_z;
    logic predict;
    logic form_s;
    logic mul_en;
    logic acc_en;
    logic acc_first;
    logic wb_det;
    logic div_start;
    logic wb_k;
    logic form_y;
    logic wb_est;
    logic wb_cov;
    logic term;
    dot_t dot;
  } kf2s_cmd_t;

  typedef struct packed {
    logic det_zero;
    logic div_done;
  } kf2s_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v[65:31] == {35{v[65]}}) begin
      r = v[31:0];
    end else if (v[65]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [64:0] v);
    logic signed [63:0] r;
    if (v[64] == v[63]) begin
      r = v[63:0];
    end else if (v[64]) begin
      r = 64'sh8000_0000_0000_0000;
    end else begin
      r = 64'sh7fff_ffff_ffff_ffff;
    end
    return r;
  endfunction

  function automatic logic signed [65:0] sx66(input logic signed [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

endpackage

### rtl/core/kalman_filter_2state.sv
// ----------------------------------------------------------------------------
// kalman_filter_2state
// Two-state Kalman filter with identity models, Q16.16 by default.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              beat
//  in       in   in_valid_i/in_stall_o    kf2s_in_t  measurement pair
//  out      out  out_valid_o/out_stall_i  kf2s_out_t estimate + skip flag
//  cfg      in   cfg_valid_i/cfg_ready_o  index + 32-bit data
//
//  One item at a time. A full update runs the one-bit-per-cycle gain divider
//  for each of the four gain terms; a singular update skips the gain, estimate
//  and covariance steps and loads its result once the determinant is known.
//  The next input beat is taken no earlier than the cycle after the load.
//  The output register frees the core: a new item is taken while a result
//  waits on a stalled output; a finished item holds while that register is
//  full and stalled. Reset clears state and the output and restores the
//  register defaults.
// ----------------------------------------------------------------------------
module kalman_filter_2state import kf2s_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kf2s_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kf2s_out_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  kf2s_cfg_t cfg_q;
  kf2s_cmd_t cmd;
  kf2s_sts_t sts;
  kf2s_out_t res;
  logic      out_valid_q;
  kf2s_out_t out_data_q;
  logic      out_free, out_load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.process_noise      <= 31'd655;
      cfg_q.dist_noise_near    <= 31'd3277;
      cfg_q.dist_noise_far     <= 31'd13107;
      cfg_q.vib_noise          <= 31'd6554;
      cfg_q.noise_switch_level <= 32'sd65536000;
      cfg_q.initial_variance   <= 31'd65536;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PROCESS_NOISE:   cfg_q.process_noise      <= cfg_data_i[30:0];
        REG_DIST_NOISE_NEAR: cfg_q.dist_noise_near    <= cfg_data_i[30:0];
        REG_DIST_NOISE_FAR:  cfg_q.dist_noise_far     <= cfg_data_i[30:0];
        REG_VIB_NOISE:       cfg_q.vib_noise          <= cfg_data_i[30:0];
        REG_SWITCH_LEVEL:    cfg_q.noise_switch_level <= cfg_data_i;
        REG_INIT_VARIANCE:   cfg_q.initial_variance   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  kf2s_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kf2s_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .res_o     (res)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/core/kf2s_div.sv
// ----------------------------------------------------------------------------
// kf2s_div
// Radix-2 restoring divider: num * 2^FRAC_BITS / den, rounded to nearest
// (ties away from zero) and saturated to signed 32 bits. One bit per cycle.
// ----------------------------------------------------------------------------
module kf2s_div import kf2s_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [63:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  localparam int Steps = 64 + FRAC_BITS;
  localparam int CntW  = $clog2(Steps + 1);

  logic            run_q, fin_q;
  logic [CntW-1:0] cnt_q;
  logic            neg_q, ovf_q;
  logic [63:0]     dvd_q, den_q, rem_q;
  logic [32:0]     quo_q;

  logic [63:0] num_mag, den_mag;
  logic [64:0] rem_sh, rem_nx;
  logic        ge;
  logic        rnd;
  logic [33:0] q_rnd, limit, q_sat;

  assign num_mag = num_i[63] ? (~num_i + 64'd1) : num_i;
  assign den_mag = den_i[63] ? (~den_i + 64'd1) : den_i;

  assign rem_sh = {rem_q, dvd_q[63]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      fin_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      fin_q <= 1'b0;
      cnt_q <= CntW'(Steps);
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_q <= 1'b0;
        fin_q <= 1'b1;
      end
    end else begin
      fin_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[63] ^ den_i[63];
      dvd_q <= num_mag;
      den_q <= den_mag;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[62:0], 1'b0};
      rem_q <= rem_nx[63:0];
      quo_q <= {quo_q[31:0], ge};
      ovf_q <= ovf_q | quo_q[32];
    end
  end

  // Round on 2*rem >= den, then clamp to the signed range of the result sign.
  always_comb begin
    rnd   = {rem_q, 1'b0} >= {1'b0, den_q};
    q_rnd = {1'b0, quo_q} + {33'd0, rnd};
    limit = neg_q ? 34'h0_8000_0000 : 34'h0_7fff_ffff;
    q_sat = (ovf_q || (q_rnd > limit)) ? limit : q_rnd;
    quo_o = neg_q ? 32'(34'd0 - q_sat) : q_sat[31:0];
  end

  assign done_o = fin_q;

endmodule

### rtl/core/kf2s_dp.sv
// ----------------------------------------------------------------------------
// kf2s_dp
// Filter datapath: state registers, one shared 33x33 multiplier with a
// saturating 64-bit accumulator, and the serial divider for the gain terms.
// ----------------------------------------------------------------------------
module kf2s_dp import kf2s_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  kf2s_cfg_t cfg_i,
  input  kf2s_in_t  in_data_i,
  input  kf2s_cmd_t cmd_i,
  output kf2s_sts_t sts_o,
  output kf2s_out_t res_o
);

  localparam logic [64:0]        Half = 65'd1 << (FRAC_BITS - 1);
  localparam logic signed [65:0] One  = 66'sd1 <<< FRAC_BITS;

  logic               started_q;
  logic               skip_q;
  kf2s_in_t           z_q;
  logic signed [31:0] est_q [2];
  logic signed [31:0] cov_q [4];
  logic signed [31:0] p_q   [4];
  logic signed [31:0] s0_q, s3_q;
  logic signed [31:0] k_q   [4];
  logic signed [31:0] y_q   [2];
  logic signed [32:0] ik_q  [4];
  logic signed [63:0] det_q;
  logic signed [63:0] prod_q;
  logic signed [63:0] acc_q;

  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod;
  logic signed [64:0] acc_sum;
  logic signed [64:0] acc65, mag65;
  logic [64:0]        mag_rnd, mag_sh;
  logic signed [65:0] rnd;
  logic signed [31:0] base0, base3;
  logic [30:0]        r_dist;
  logic               div_done;
  logic signed [31:0] div_quo;

  function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  function automatic logic signed [32:0] ng33(input logic signed [31:0] v);
    return 33'sd0 - {v[31], v};
  endfunction

  // Operand select for the current dot product term.
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd_i.dot)
      DOT_DET: begin
        op_a = cmd_i.term ? sx33(p_q[1]) : sx33(s0_q);
        op_b = cmd_i.term ? ng33(p_q[2]) : sx33(s3_q);
      end
      DOT_K0: begin
        op_a = cmd_i.term ? sx33(p_q[1]) : sx33(p_q[0]);
        op_b = cmd_i.term ? ng33(p_q[2]) : sx33(s3_q);
      end
      DOT_K1: begin
        op_a = cmd_i.term ? sx33(p_q[1]) : sx33(p_q[0]);
        op_b = cmd_i.term ? sx33(s0_q)   : ng33(p_q[1]);
      end
      DOT_K2: begin
        op_a = cmd_i.term ? sx33(p_q[3]) : sx33(p_q[2]);
        op_b = cmd_i.term ? ng33(p_q[2]) : sx33(s3_q);
      end
      DOT_K3: begin
        op_a = cmd_i.term ? sx33(p_q[3]) : sx33(p_q[2]);
        op_b = cmd_i.term ? sx33(s0_q)   : ng33(p_q[1]);
      end
      DOT_EST0: begin
        op_a = cmd_i.term ? sx33(k_q[1]) : sx33(k_q[0]);
        op_b = cmd_i.term ? sx33(y_q[1]) : sx33(y_q[0]);
      end
      DOT_EST1: begin
        op_a = cmd_i.term ? sx33(k_q[3]) : sx33(k_q[2]);
        op_b = cmd_i.term ? sx33(y_q[1]) : sx33(y_q[0]);
      end
      DOT_COV0: begin
        op_a = cmd_i.term ? ik_q[1] : ik_q[0];
        op_b = cmd_i.term ? sx33(p_q[2]) : sx33(p_q[0]);
      end
      DOT_COV1: begin
        op_a = cmd_i.term ? ik_q[1] : ik_q[0];
        op_b = cmd_i.term ? sx33(p_q[3]) : sx33(p_q[1]);
      end
      DOT_COV2: begin
        op_a = cmd_i.term ? ik_q[3] : ik_q[2];
        op_b = cmd_i.term ? sx33(p_q[2]) : sx33(p_q[0]);
      end
      DOT_COV3: begin
        op_a = cmd_i.term ? ik_q[3] : ik_q[2];
        op_b = cmd_i.term ? sx33(p_q[3]) : sx33(p_q[1]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Operands stay within +-2^31, so the product fits 64 bits exactly.
  assign prod    = op_a * op_b;
  assign acc_sum = (cmd_i.acc_first ? 65'sd0 : {acc_q[63], acc_q}) + {prod_q[63], prod_q};

  // Accumulator / 2^F, round half away from zero.
  always_comb begin
    acc65   = {acc_q[63], acc_q};
    mag65   = acc_q[63] ? (65'sd0 - acc65) : acc65;
    mag_rnd = mag65 + Half;
    mag_sh  = mag_rnd >> FRAC_BITS;
    rnd     = acc_q[63] ? (66'sd0 - $signed({1'b0, mag_sh})) : $signed({1'b0, mag_sh});
  end

  assign base0  = started_q ? cov_q[0] : $signed({1'b0, cfg_i.initial_variance});
  assign base3  = started_q ? cov_q[3] : $signed({1'b0, cfg_i.initial_variance});
  assign r_dist = (z_q.measured_distance < cfg_i.noise_switch_level) ?
                  cfg_i.dist_noise_near : cfg_i.dist_noise_far;

  kf2s_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (acc_q),
    .den_i   (det_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      skip_q    <= 1'b0;
      est_q[0]  <= '0;
      est_q[1]  <= '0;
      cov_q[0]  <= '0;
      cov_q[1]  <= '0;
      cov_q[2]  <= '0;
      cov_q[3]  <= '0;
    end else begin
      if (cmd_i.predict) begin
        started_q <= 1'b1;
        cov_q[0]  <= sat32(sx66(base0) + {35'd0, cfg_i.process_noise});
        cov_q[3]  <= sat32(sx66(base3) + {35'd0, cfg_i.process_noise});
        if (!started_q) begin
          cov_q[1] <= '0;
          cov_q[2] <= '0;
          est_q[0] <= z_q.measured_distance;
          est_q[1] <= z_q.measured_vibration;
        end
      end
      if (cmd_i.wb_det) begin
        skip_q <= (acc_q == 64'sd0);
      end
      if (cmd_i.wb_est) begin
        if (cmd_i.dot == DOT_EST0) begin
          est_q[0] <= sat32(sx66(est_q[0]) + rnd);
        end else begin
          est_q[1] <= sat32(sx66(est_q[1]) + rnd);
        end
      end
      if (cmd_i.wb_cov) begin
        case (cmd_i.dot)
          DOT_COV0: cov_q[0] <= sat32(rnd);
          DOT_COV1: cov_q[1] <= sat32(rnd);
          DOT_COV2: cov_q[2] <= sat32(rnd);
          default:  cov_q[3] <= sat32(rnd);
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_z) begin
      z_q <= in_data_i;
    end
    if (cmd_i.form_s) begin
      p_q[0] <= cov_q[0];
      p_q[1] <= cov_q[1];
      p_q[2] <= cov_q[2];
      p_q[3] <= cov_q[3];
      s0_q   <= sat32(sx66(cov_q[0]) + {35'd0, r_dist});
      s3_q   <= sat32(sx66(cov_q[3]) + {35'd0, cfg_i.vib_noise});
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod[63:0];
    end
    if (cmd_i.acc_en) begin
      acc_q <= sat64(acc_sum);
    end
    if (cmd_i.wb_det) begin
      det_q <= acc_q;
    end
    if (cmd_i.wb_k) begin
      case (cmd_i.dot)
        DOT_K0:  k_q[0] <= div_quo;
        DOT_K1:  k_q[1] <= div_quo;
        DOT_K2:  k_q[2] <= div_quo;
        default: k_q[3] <= div_quo;
      endcase
    end
    if (cmd_i.form_y) begin
      y_q[0]  <= sat32(sx66(z_q.measured_distance) - sx66(est_q[0]));
      y_q[1]  <= sat32(sx66(z_q.measured_vibration) - sx66(est_q[1]));
      ik_q[0] <= sx33(sat32(One - sx66(k_q[0])));
      ik_q[1] <= ng33(k_q[1]);
      ik_q[2] <= ng33(k_q[2]);
      ik_q[3] <= sx33(sat32(One - sx66(k_q[3])));
    end
  end

  assign sts_o.det_zero = (acc_q == 64'sd0);
  assign sts_o.div_done = div_done;

  assign res_o.filtered_distance  = est_q[0];
  assign res_o.filtered_vibration = est_q[1];
  assign res_o.update_skipped     = skip_q;

endmodule

### rtl/core/kf2s_ctrl.sv
// ----------------------------------------------------------------------------
// kf2s_ctrl
// Sequencer: walks predict, the eleven two-term dot products, the four gain
// divisions and the write-backs, then hands the result to the output stage.
// ----------------------------------------------------------------------------
module kf2s_ctrl import kf2s_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      out_free_i,
  output logic      out_load_o,
  input  kf2s_sts_t sts_i,
  output kf2s_cmd_t cmd_o
);

  kf2s_state_e state_q, state_d;
  dot_t        dot_q, dot_d;
  logic        term_q, term_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dot_q   <= DOT_DET;
      term_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      dot_q   <= dot_d;
      term_q  <= term_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    dot_d      = dot_q;
    term_d     = term_q;
    cmd_o      = '0;
    cmd_o.dot  = dot_q;
    cmd_o.term = term_q;
    in_stall_o = 1'b1;
    out_load_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_z = 1'b1;
          state_d      = ST_PRED;
        end
      end
      ST_PRED: begin
        cmd_o.predict = 1'b1;
        state_d       = ST_FORMS;
      end
      ST_FORMS: begin
        cmd_o.form_s = 1'b1;
        dot_d        = DOT_DET;
        term_d       = 1'b0;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en    = 1'b1;
        cmd_o.acc_first = !term_q;
        term_d          = !term_q;
        state_d         = term_q ? ST_POST : ST_MUL;
      end
      ST_POST: begin
        if (dot_q == DOT_DET) begin
          cmd_o.wb_det = 1'b1;
          if (sts_i.det_zero) begin
            state_d = ST_OUT;
          end else begin
            dot_d   = DOT_K0;
            state_d = ST_MUL;
          end
        end else if (dot_q <= DOT_K3) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else if (dot_q <= DOT_EST1) begin
          cmd_o.wb_est = 1'b1;
          dot_d        = dot_q + 1'b1;
          state_d      = ST_MUL;
        end else begin
          cmd_o.wb_cov = 1'b1;
          if (dot_q == DOT_COV3) begin
            state_d = ST_OUT;
          end else begin
            dot_d   = dot_q + 1'b1;
            state_d = ST_MUL;
          end
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.wb_k = 1'b1;
          if (dot_q == DOT_K3) begin
            state_d = ST_FORMY;
          end else begin
            dot_d   = dot_q + 1'b1;
            state_d = ST_MUL;
          end
        end
      end
      ST_FORMY: begin
        cmd_o.form_y = 1'b1;
        dot_d        = DOT_EST0;
        state_d      = ST_MUL;
      end
      ST_OUT: begin
        // hold until the output register can take the beat
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/core/kf2s_chk.sv
// ----------------------------------------------------------------------------
// kf2s_chk
// Port-level checks for the Kalman filter, bound to the top level.
// ----------------------------------------------------------------------------
module kf2s_chk import kf2s_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_i,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input kf2s_out_t out_data_i
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat changed while stalled");

  // one item in flight: input stalls right after a beat is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("second item taken while one is in flight");

  // no result appears in the cycle after an input beat
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> !$rose(out_valid_i))
    else $error("result raised too early after input beat");

endmodule

bind kalman_filter_2state kf2s_chk u_kf2s_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

### dv/kalman_filter_2state_checker.sv
// ----------------------------------------------------------------------------
// kalman_filter_2state_checker
// Watches the measurement, estimate and register channels of the two-state
// Kalman filter, predicts every estimate beat in fixed point and compares it.
// ----------------------------------------------------------------------------
module kalman_filter_2state_checker import kf2s_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  kf2s_in_t           in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  kf2s_out_t          out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint I64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint I64_MIN = 64'sh8000_0000_0000_0000;

  kf2s_cfg_t    regs;
  longint       est [2];
  longint       cov [4];
  bit           started;
  kf2s_out_t    expected_estimates [$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint add_sat64(longint a, longint b);
    if (b > 0 && a > I64_MAX - b) return I64_MAX;
    if (b < 0 && a < I64_MIN - b) return I64_MIN;
    return a + b;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? 64'd0 - longint'(unsigned'(v)) : longint'(unsigned'(v));
  endfunction

  function automatic longint round_shift(longint v);
    longint unsigned m;
    m = (magnitude(v) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint gain_div(longint num, longint den);
    bit neg, sat;
    longint unsigned un, ud, lim, q, r;
    neg = (num < 0) != (den < 0);
    un = magnitude(num);
    ud = magnitude(den);
    lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    q = un / ud;
    r = un % ud;
    sat = q > lim;
    for (int i = 0; i < FRAC_BITS && !sat; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= ud) begin
        r = r - ud;
        q = q | 64'd1;
      end
      if (q > lim) sat = 1;
    end
    if (!sat && r >= ud - r) q = q + 1;
    if (sat || q > lim) q = lim;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint mac2(longint a0, longint b0, longint a1, longint b1);
    return add_sat64(a0 * b0, a1 * b1);
  endfunction

  function automatic kf2s_out_t filter_step(kf2s_in_t m);
    longint z0, z1, det, y0, y1, r0, one;
    longint p [4];
    longint s [4];
    longint adj [4];
    longint k [4];
    longint ik [4];
    kf2s_out_t res;
    z0 = longint'(m.measured_distance);
    z1 = longint'(m.measured_vibration);
    one = 64'sd1 << FRAC_BITS;
    if (!started) begin
      est[0] = z0;
      est[1] = z1;
      cov[0] = longint'(regs.initial_variance);
      cov[1] = 0;
      cov[2] = 0;
      cov[3] = longint'(regs.initial_variance);
      started = 1;
    end
    cov[0] = clamp32(cov[0] + longint'(regs.process_noise));
    cov[3] = clamp32(cov[3] + longint'(regs.process_noise));
    p = cov;
    r0 = (z0 < longint'(regs.noise_switch_level)) ? longint'(regs.dist_noise_near)
                                                   : longint'(regs.dist_noise_far);
    s[0] = clamp32(p[0] + r0);
    s[1] = p[1];
    s[2] = p[2];
    s[3] = clamp32(p[3] + longint'(regs.vib_noise));
    det = add_sat64(s[0] * s[3], -(s[1] * s[2]));
    res.update_skipped = (det == 0);
    if (det != 0) begin
      adj[0] = s[3];
      adj[1] = -s[1];
      adj[2] = -s[2];
      adj[3] = s[0];
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          k[i*2+j] = gain_div(mac2(p[i*2], adj[j], p[i*2+1], adj[2+j]), det);
      y0 = clamp32(z0 - est[0]);
      y1 = clamp32(z1 - est[1]);
      for (int i = 0; i < 2; i++)
        est[i] = clamp32(est[i] + round_shift(mac2(k[i*2], y0, k[i*2+1], y1)));
      ik[0] = clamp32(one - k[0]);
      ik[1] = -k[1];
      ik[2] = -k[2];
      ik[3] = clamp32(one - k[3]);
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          cov[i*2+j] = clamp32(round_shift(mac2(ik[i*2], p[j], ik[i*2+1], p[2+j])));
    end
    res.filtered_distance = est[0][31:0];
    res.filtered_vibration = est[1][31:0];
    return res;
  endfunction

  assign pending_o = expected_estimates.size();

  always @(posedge clk_i or negedge rst_ni) begin
    kf2s_out_t want;
    if (!rst_ni) begin
      regs.process_noise <= 31'd655;
      regs.dist_noise_near <= 31'd3277;
      regs.dist_noise_far <= 31'd13107;
      regs.vib_noise <= 31'd6554;
      regs.noise_switch_level <= 32'sd65536000;
      regs.initial_variance <= 31'd65536;
      for (int i = 0; i < 2; i++) est[i] = 0;
      for (int i = 0; i < 4; i++) cov[i] = 0;
      started = 0;
      expected_estimates.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_PROCESS_NOISE:   regs.process_noise <= cfg_data_i[30:0];
          REG_DIST_NOISE_NEAR: regs.dist_noise_near <= cfg_data_i[30:0];
          REG_DIST_NOISE_FAR:  regs.dist_noise_far <= cfg_data_i[30:0];
          REG_VIB_NOISE:       regs.vib_noise <= cfg_data_i[30:0];
          REG_SWITCH_LEVEL:    regs.noise_switch_level <= cfg_data_i;
          REG_INIT_VARIANCE:   regs.initial_variance <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_estimates.push_back(filter_step(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_estimates.size() == 0) begin
          $display("%0t: unexpected estimate beat %h", $realtime, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_estimates.pop_front();
          if (want !== out_data_i) begin
            $display("%0t: estimate mismatch expected dist %0d vib %0d skip %0b, got %0d %0d %0b",
                     $realtime, want.filtered_distance, want.filtered_vibration,
                     want.update_skipped, out_data_i.filtered_distance,
                     out_data_i.filtered_vibration, out_data_i.update_skipped);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

### dv/kalman_filter_2state_tb.sv
// ----------------------------------------------------------------------------
// kalman_filter_2state_tb
// Drives measurement pairs in bursts with random gaps and a randomly stalling
// receiver across several register settings, then reports the verdict.
// ----------------------------------------------------------------------------
module kalman_filter_2state_tb import kf2s_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  kf2s_in_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 0;
  kf2s_out_t          out_data;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;
  bit                 hold_off = 0;

  always #10 clk = ~clk;

  kalman_filter_2state dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  kalman_filter_2state_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver: own stall pattern, or a long hold-off when asked.
  always @(posedge clk) begin
    int mode;
    mode = $urandom_range(0, 3);
    if (hold_off) out_stall <= 1;
    else if (mode == 0) out_stall <= ($urandom_range(0, 1) == 0);
    else out_stall <= ($urandom_range(0, 9) < 2);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("kalman_filter_2state_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 131071)) - 32'd65536;
      3: return $urandom;
      4: return 32'(6553600) + 32'($urandom_range(0, 2000000));
      default: return 32'($urandom_range(0, 200 << 16));
    endcase
  endfunction

  task automatic send_pair(logic [31:0] d, logic [31:0] v);
    in_valid <= 1;
    in_data <= {d, v};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender();
    in_valid <= 0;
    repeat ($urandom_range(1, 40)) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic random_burst(int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 30);
      for (int i = 0; i < burst && left > 0; i++, left--) send_pair(rand_word(), rand_word());
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
    in_valid <= 0;
  endtask

  task automatic program_all(logic [31:0] q, logic [31:0] rn, logic [31:0] rf,
                             logic [31:0] rv, logic [31:0] lvl, logic [31:0] p0);
    write_reg(REG_PROCESS_NOISE, q);
    write_reg(REG_DIST_NOISE_NEAR, rn);
    write_reg(REG_DIST_NOISE_FAR, rf);
    write_reg(REG_VIB_NOISE, rv);
    write_reg(REG_SWITCH_LEVEL, lvl);
    write_reg(REG_INIT_VARIANCE, p0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Out-of-range index must be ignored.
    write_reg(3'd7, 32'hffff_ffff);
    write_reg(3'd6, 32'h1234_5678);
    // Directed: first sample load, extremes, near and far noise.
    send_pair(32'd0, 32'd0);
    send_pair(32'h7fff_ffff, 32'h7fff_ffff);
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'd65536000, 32'd65536);
    send_pair(32'd65535999, 32'hffff_0000);
    send_pair(32'h7fff_ffff, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h7fff_ffff);
    drain();
    // Zero noise and zero variance: singular S, correction skipped.
    program_all(32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'd0);
    random_burst(5);
    drain();
    // Maximum noise and variance: saturation paths; extra bit 31 dropped.
    program_all(32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'hffff_ffff,
                32'h7fff_ffff, 32'hffff_ffff);
    send_pair(32'h7fff_ffff, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h7fff_ffff);
    random_burst(8);
    drain();
    // Long receiver hold-off while the sender keeps offering.
    program_all(32'd655, 32'd3277, 32'd13107, 32'd6554, 32'd65536000, 32'd65536);
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      random_burst(10);
    join
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      program_all($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 22), $urandom,
                  $urandom_range(0, 1 << 22), rand_word(), $urandom);
      random_burst(270);
      drain();
    end
    if (fail_count == 0) begin
      $display("kalman_filter_2state_tb: PASS");
    end else begin
      $display("kalman_filter_2state_tb: FAIL");
    end
    $finish;
  end
endmodule
